>>> sv/accel_tilt_pitch_roll_top_macros.svh
// assertion macros for the tilt angle block
`ifndef ACCEL_TILT_PITCH_ROLL_TOP_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ATP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tilt block assertion failed");
`define ATP_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("tilt block assertion failed");
`else
`define ATP_ASSERT(name, clk, rst_n, prop)
`define ATP_ASSERT_NR(name, clk, prop)
`endif

`endif

>>> sv/atp_pkg.sv
// types and constants shared by the tilt angle datapath
package atp_pkg;

    localparam int IN_W        = 16;
    localparam int NUM_W       = 17;
    localparam int SQR_W       = 31;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = 34;
    localparam int XY_W        = 35;
    localparam int Z_W         = 32;
    localparam int OUT_W       = 15;
    localparam int ROOT_STEPS  = 32;
    localparam int STAGE_LIMIT = 24;
    localparam int FRAC_IN     = 16;
    localparam int DEG_MUL     = 45;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [Z_W-1:0] STAGE_ANGLE [STAGE_LIMIT] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef struct packed {
        logic zero_num;
        logic zero_den;
        logic num_neg;
    } flag_t;

    typedef struct packed {
        logic [SQR_W-1:0]        p2;
        logic [SQR_W-1:0]        q2;
        logic signed [NUM_W-1:0] num;
        flag_t                   flags;
    } sqr_t;

    typedef struct packed {
        logic [SQ_W-1:0]         sq;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [NUM_W-1:0] num;
        flag_t                   flags;
    } root_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        flag_t                  flags;
    } vec_t;

endpackage

>>> sv/accel_tilt_pitch_roll_top.sv
// path to m_tvalid: squares, sum, root row, cordic row, conversion, angle, output registers
// throughput: one word per cycle unless the skid stage is full; cell rows fully unrolled
// a two-entry output register and skid stage keeps s_tready registered
// aresetn (synchronous, active low) clears the valid chain, output and skid flags
// datapath registers are not reset
module accel_tilt_pitch_roll_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pitch_deg, roll_deg, 2 zero bits
);
    import atp_pkg::*;

    `include "accel_tilt_pitch_roll_top_macros.svh"

    localparam int NSTG = (CORDIC_STAGES < STAGE_LIMIT) ? CORDIC_STAGES : STAGE_LIMIT;
    localparam int LAT  = 4 + ROOT_STEPS + NSTG;

    logic                    en;
    logic [IN_W-1:0]         ax;
    logic [IN_W-1:0]         ay;
    logic [IN_W-1:0]         az;
    logic signed [NUM_W-1:0] pitch_num;
    logic signed [NUM_W-1:0] roll_num;
    logic [OUT_W-1:0]        pitch;
    logic [OUT_W-1:0]        roll;
    logic [2*OUT_W-1:0]      lane_data;
    logic [LAT-1:0]          vld_reg;
    logic                    m_tvalid_reg;
    logic [2*OUT_W-1:0]      m_data_reg;
    logic                    skid_valid_reg;
    logic [2*OUT_W-1:0]      skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign ax = s_tdata[IN_W-1:0];
    assign ay = s_tdata[2*IN_W-1:IN_W];
    assign az = s_tdata[3*IN_W-1:2*IN_W];

    assign pitch_num = NUM_W'(0) - {ax[IN_W-1], ax};
    assign roll_num  = {ay[IN_W-1], ay};

    atp_lane #(
        .NSTG (NSTG),
        .FRAC (ANGLE_FRAC_BITS)
    ) u_pitch (
        .aclk  (aclk),
        .en    (en),
        .num   (pitch_num),
        .p     ($signed(ay)),
        .q     ($signed(az)),
        .angle (pitch)
    );

    atp_lane #(
        .NSTG (NSTG),
        .FRAC (ANGLE_FRAC_BITS)
    ) u_roll (
        .aclk  (aclk),
        .en    (en),
        .num   (roll_num),
        .p     ($signed(ax)),
        .q     ($signed(az)),
        .angle (roll)
    );

    assign lane_data = {roll, pitch};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[LAT-1]) begin
            if (!m_tvalid_reg || m_tready) begin
                m_data_reg   <= lane_data;
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= lane_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    `ATP_ASSERT(a_skid_needs_out, aclk, aresetn, skid_valid_reg |-> m_tvalid_reg)
    `ATP_ASSERT(a_skid_after_stall, aclk, aresetn, skid_valid_reg |-> !$past(m_tready))
    `ATP_ASSERT(a_pipe_end_lands, aclk, aresetn, (vld_reg[LAT-1] && !skid_valid_reg) |=> m_tvalid_reg)

endmodule

>>> sv/atp_root_cell.sv
// one digit cell of the pipelined square root row
module atp_root_cell #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  atp_pkg::root_t  d_in,
    output atp_pkg::root_t  d_out
);
    import atp_pkg::*;

    localparam int LO = (STEP >= ROOT_STEPS / 2) ? 2 * STEP - ROOT_STEPS : 0;

    logic [1:0]       pair;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    root_t            d_next;
    root_t            d_reg;

    // radicand is sq << 32, so the low half of its digits are zero
    assign pair   = (STEP >= ROOT_STEPS / 2) ? d_in.sq[LO+1:LO] : 2'b00;
    assign rem_sh = {d_in.rem[REM_W-3:0], pair};
    assign trial  = {d_in.root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        d_next      = d_in;
        d_next.rem  = ge ? (rem_sh - trial) : rem_sh;
        d_next.root = {d_in.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> sv/atp_cordic_cell.sv
// one vectoring stage of the cordic row
module atp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  atp_pkg::vec_t  d_in,
    output atp_pkg::vec_t  d_out
);
    import atp_pkg::*;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;
    vec_t                   d_next;
    vec_t                   d_reg;

    assign dx  = d_in.y >>> IDX;
    assign dy  = d_in.x >>> IDX;
    assign ang = $signed(STAGE_ANGLE[IDX]);

    always_comb begin
        d_next = d_in;
        if (!d_in.y[XY_W-1]) begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + ang;
        end else begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> sv/atp_lane.sv
// one angle lane: squares, root cell row, cordic cell row, degree conversion
module atp_lane #(
    parameter int NSTG = 16,
    parameter int FRAC = 7
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [atp_pkg::NUM_W-1:0] num,
    input  logic signed [atp_pkg::IN_W-1:0]  p,
    input  logic signed [atp_pkg::IN_W-1:0]  q,
    output logic [atp_pkg::OUT_W-1:0]        angle
);
    import atp_pkg::*;

    `include "accel_tilt_pitch_roll_top_macros.svh"

    localparam int PROD_W = Z_W + 6;
    localparam int SC_W   = PROD_W + FRAC + 1;
    localparam int MAG_W  = SC_W - 29;
    localparam int DEG_W  = MAG_W + 1;
    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(90) << FRAC;
    localparam logic [OUT_W-1:0] LIMIT_OUT = OUT_W'(LIMIT);

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              z_neg;
        flag_t             flags;
    } conv_t;

    logic signed [2*IN_W-1:0] p2_full;
    logic signed [2*IN_W-1:0] q2_full;
    sqr_t                     s0_reg;
    logic [SQ_W-1:0]          sq_sum;
    root_t                    s1_reg;
    root_t                    root_chain [ROOT_STEPS+1];
    vec_t                     vec_chain [NSTG+1];
    logic signed [Z_W-1:0]    z_fin;
    logic [Z_W-1:0]           z_abs;
    conv_t                    conv_reg;
    logic [SC_W-1:0]          scaled;
    logic [MAG_W-1:0]         mag;
    logic signed [DEG_W-1:0]  deg;
    logic [OUT_W-1:0]         angle_next;
    logic [OUT_W-1:0]         angle_reg;

    assign p2_full = p * p;
    assign q2_full = q * q;

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg.p2             <= p2_full[SQR_W-1:0];
            s0_reg.q2             <= q2_full[SQR_W-1:0];
            s0_reg.num            <= num;
            s0_reg.flags.zero_num <= (num == '0);
            s0_reg.flags.zero_den <= (p == '0) && (q == '0);
            s0_reg.flags.num_neg  <= num[NUM_W-1];
        end
    end

    assign sq_sum = {1'b0, s0_reg.p2} + {1'b0, s0_reg.q2};

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg.sq    <= sq_sum;
            s1_reg.rem   <= '0;
            s1_reg.root  <= '0;
            s1_reg.num   <= s0_reg.num;
            s1_reg.flags <= s0_reg.flags;
        end
    end

    assign root_chain[0] = s1_reg;

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        atp_root_cell #(
            .STEP (ROOT_STEPS - 1 - j)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (root_chain[j]),
            .d_out (root_chain[j+1])
        );
    end

    // x = floor(sqrt(sq) * 2^16), y = num * 2^16
    assign vec_chain[0].x     = $signed({{(XY_W-ROOT_W){1'b0}}, root_chain[ROOT_STEPS].root});
    assign vec_chain[0].y     = XY_W'($signed({root_chain[ROOT_STEPS].num, {FRAC_IN{1'b0}}}));
    assign vec_chain[0].z     = '0;
    assign vec_chain[0].flags = root_chain[ROOT_STEPS].flags;

    for (genvar i = 0; i < NSTG; i++) begin : g_cordic
        atp_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (vec_chain[i]),
            .d_out (vec_chain[i+1])
        );
    end

    assign z_fin = vec_chain[NSTG].z;
    assign z_abs = z_fin[Z_W-1] ? Z_W'(-z_fin) : Z_W'(z_fin);

    always_ff @(posedge aclk) begin
        if (en) begin
            conv_reg.prod  <= PROD_W'(z_abs) * PROD_W'(DEG_MUL);
            conv_reg.z_neg <= z_fin[Z_W-1];
            conv_reg.flags <= vec_chain[NSTG].flags;
        end
    end

    // 2^32 per turn to degrees: times 45, over 2^29, round half away from zero
    assign scaled = (SC_W'(conv_reg.prod) << FRAC) + (SC_W'(1) << 28);

    always_comb begin
        mag = scaled[SC_W-1:29];
        if (mag > LIMIT) begin
            mag = LIMIT;
        end
        deg = conv_reg.z_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (conv_reg.flags.zero_num) begin
            angle_next = '0;
        end else if (conv_reg.flags.zero_den) begin
            angle_next = conv_reg.flags.num_neg ? OUT_W'(-$signed({1'b0, LIMIT}))
                                                : OUT_W'(LIMIT);
        end else begin
            angle_next = deg[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

    `ATP_ASSERT_NR(a_zero_num_gives_zero, aclk, (en && conv_reg.flags.zero_num) |=> (angle_reg == '0))
    `ATP_ASSERT_NR(a_zero_den_pos_limit, aclk, (en && conv_reg.flags.zero_den && !conv_reg.flags.zero_num && !conv_reg.flags.num_neg) |=> (angle_reg == LIMIT_OUT))
    `ATP_ASSERT_NR(a_hold_when_stalled, aclk, !en |=> $stable(angle_reg))

endmodule

>>> test/tb_accel_tilt_pitch_roll_top.sv
// self-checking testbench for the pitch and roll tilt angle pipeline
module tb_accel_tilt_pitch_roll_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 16;
    localparam int FRAC        = 7;
    localparam int N_PHASE     = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 80;
    localparam int N_DIRECTED  = 23;

    // atan(2^-i), 2^32 per turn
    localparam longint ATAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    typedef enum int {
        SHAPE_FULL,
        SHAPE_SMALL,
        SHAPE_AXIS,
        SHAPE_STEEP,
        SHAPE_EDGE
    } shape_e;

    class tilt_angle_board;
        typedef struct {
            logic [14:0] pitch;
            logic [14:0] roll;
        } angles_t;

        angles_t     expected_angles[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= n)
                    r = t;
            end
            return r;
        endfunction

        function logic [14:0] tilt_deg(longint num, longint p, longint q);
            longint unsigned sq;
            longint x, y, z, dx, dy, mag, lim, deg;
            lim = 90 * (64'sd1 << FRAC);
            sq = p * p + q * q;
            if (num == 0) begin
                deg = 0;
            end else if (sq == 0) begin
                deg = (num > 0) ? lim : -lim;
            end else begin
                x = longint'(int_root(sq << 32));
                y = num * 65536;
                z = 0;
                for (int i = 0; i < STAGES && i < 24; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x = x + dx;
                        y = y - dy;
                        z = z + ATAN_STEP[i];
                    end else begin
                        x = x - dx;
                        y = y + dy;
                        z = z - ATAN_STEP[i];
                    end
                end
                mag = (z < 0) ? -z : z;
                mag = ((mag * 45) << FRAC) + (64'sd1 << 28);
                mag = mag >>> 29;
                if (mag > lim)
                    mag = lim;
                deg = (z < 0) ? -mag : mag;
            end
            return deg[14:0];
        endfunction

        function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az);
            angles_t a;
            a.pitch = tilt_deg(-longint'(ax), longint'(ay), longint'(az));
            a.roll  = tilt_deg(longint'(ay), longint'(ax), longint'(az));
            expected_angles.push_back(a);
        endfunction

        function void check_angles(logic [31:0] word);
            angles_t a;
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected word %h", $time, word);
                mismatches++;
                return;
            end
            a = expected_angles.pop_front();
            if (word[14:0] !== a.pitch) begin
                $display("%0t: pitch expected %0d actual %0d", $time,
                         $signed(a.pitch), $signed(word[14:0]));
                mismatches++;
            end
            if (word[29:15] !== a.roll) begin
                $display("%0t: roll expected %0d actual %0d", $time,
                         $signed(a.roll), $signed(word[29:15]));
                mismatches++;
            end
            if (word[31:30] !== 2'b00) begin
                $display("%0t: pad bits expected 0 actual %b", $time, word[31:30]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // accel_x, accel_y, accel_z
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pitch_deg, roll_deg, 2 zero bits

    tilt_angle_board board;
    int          send_idle;
    int          recv_stall;
    int unsigned idle_cycles;

    accel_tilt_pitch_roll_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_angles(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** accel_tilt_pitch_roll_top: FAILED **");
            $finish;
        end
    end

    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        do
            @(posedge aclk);
        while (!s_tready);
        board.note_sample(ax, ay, az);
    endtask

    function automatic logic signed [15:0] edge_value();
        case ($urandom_range(5))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic send_random();
        logic signed [15:0] v [3];
        shape_e             shape;
        int                 big;
        int                 zmask;
        shape = shape_e'($urandom_range(4));
        for (int k = 0; k < 3; k++)
            v[k] = $urandom;
        case (shape)
            SHAPE_FULL: begin
            end
            SHAPE_SMALL: begin
                for (int k = 0; k < 3; k++)
                    v[k] = int'($urandom_range(512)) - 256;
            end
            SHAPE_AXIS: begin
                zmask = $urandom_range(1, 6);
                for (int k = 0; k < 3; k++)
                    if (zmask[k])
                        v[k] = 0;
            end
            SHAPE_STEEP: begin
                big = $urandom_range(2);
                for (int k = 0; k < 3; k++)
                    if (k != big)
                        v[k] = int'($urandom_range(128)) - 64;
            end
            SHAPE_EDGE: begin
                for (int k = 0; k < 3; k++)
                    v[k] = edge_value();
            end
        endcase
        send_sample(v[0], v[1], v[2]);
    endtask

    // x, y, z triples covering zero denominators, zero numerators and extremes
    int dir_x [N_DIRECTED] = '{0, 1000, -1000, 0, 0, 0, 0, -32768, 32767, 0, 0,
                               32767, -32768, -32768, 1, 0, 1, -1, 16384, 0,
                               12345, -32768, 32767};
    int dir_y [N_DIRECTED] = '{0, 0, 0, 1000, -1000, 0, 0, 0, 0, -32768, 32767,
                               32767, -32768, 32767, 0, 1, 1, -1, 0, 0,
                               -23456, -32768, 1};
    int dir_z [N_DIRECTED] = '{0, 0, 0, 0, 0, 1000, -32768, 0, 0, 0, 0,
                               32767, -32768, 0, 0, 0, 1, -1, 16384, 16384,
                               3456, 0, 0};

    initial begin
        board       = new();
        send_idle   = 0;
        recv_stall  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(dir_x[i], dir_y[i], dir_z[i]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 60; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 60; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            for (int n = 0; n < N_PHASE; n++)
                send_random();
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.expected_angles.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_angles.size() == 0)
            $display("** accel_tilt_pitch_roll_top: PASSED **");
        else
            $display("** accel_tilt_pitch_roll_top: FAILED **");
        $finish;
    end
endmodule
